/* hw/rtl/sliding_window_retransmit_endpoint_macros.svh */
// assertion helpers used by the endpoint module
`ifndef SLIDING_WINDOW_RETRANSMIT_ENDPOINT_MACROS_SVH
`define SLIDING_WINDOW_RETRANSMIT_ENDPOINT_MACROS_SVH

// immediate implication checked every cycle outside reset
`define SWR_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define SWR_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/swr_pkg.sv */
package swr_pkg;

   localparam int WINDOW      = 8;
   localparam int SEQ_MODULO  = 256;
   localparam int MULT_RESET  = SEQ_MODULO / WINDOW;
   localparam int TX_LIMIT    = (WINDOW < 8) ? WINDOW : 8;

   localparam logic [1:0] ACT_SEND = 2'd0;
   localparam logic [1:0] ACT_TICK = 2'd1;
   localparam logic [1:0] ACT_ACK  = 2'd2;
   localparam logic [1:0] ACT_RECV = 2'd3;

   localparam logic [0:0] REG_MAX_RETRIES = 1'b0;

   typedef struct packed {
      logic [3:0]  retries;
      logic [7:0]  seq;
      logic [15:0] tag;
   } entry_type;

   typedef struct packed {
      logic      shift;
      logic      load;
      entry_type data;
   } cell_ctl_type;

endpackage

/* hw/rtl/swr_req_if.sv */
interface swr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] msg_tag;
   logic [7:0]  seq_in;

   modport source (output valid, action, msg_tag, seq_in, input ready);
   modport sink (input valid, action, msg_tag, seq_in, output ready);
endinterface

/* hw/rtl/swr_rsp_if.sv */
interface swr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] out_tag;
   logic [7:0]  out_seq;
   logic        accepted;
   logic        queue_full;
   logic        arm_timer;
   logic [4:0]  pending;
   logic        last;

   modport source (output valid, kind, out_tag, out_seq, accepted, queue_full, arm_timer,
                   pending, last, input ready);
   modport sink (input valid, kind, out_tag, out_seq, accepted, queue_full, arm_timer,
                 pending, last, output ready);
endinterface

/* hw/rtl/sliding_window_retransmit_endpoint.sv */
// Sliding-window retransmit endpoint. Requests are send (0), timer tick (1), ack (2) and
// receive (3); each request yields one to eight results, the final one flagged by last, and
// every result carries the queue occupancy left after the request. The retransmit queue is a
// row of QUEUE_DEPTH cells with the head in cell 0; the whole row shifts one step toward the
// head per cycle during a pass. Send and receive each go straight to a single result. A tick
// passes every queued entry through the row, then emits its results; an ack pops the entries
// it covers from the head and then runs a tick pass, but an ack that empties the queue goes
// straight to its single result. One request is in flight at a time.
// max_retries sits at byte address 0 of the register port and applies to messages queued
// after it is written.
`include "sliding_window_retransmit_endpoint_macros.svh"

module sliding_window_retransmit_endpoint #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   swr_req_if.sink         req_ch,
   swr_rsp_if.source       rsp_ch,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [2:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int TX_LIMIT_N = swr_pkg::TX_LIMIT;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PASS = 2'd1;
   localparam logic [1:0] ST_ACK  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [3:0]    writes_ff, writes_in;
   logic [3:0]    k_ff, k_in;
   logic [3:0]    nres_ff, nres_in;
   logic          use_buf_ff, use_buf_in;
   logic          sr_kind_ff, sr_kind_in;
   logic [15:0]   sr_tag_ff, sr_tag_in;
   logic [7:0]    sr_seq_ff, sr_seq_in;
   logic          sr_acc_ff, sr_acc_in;
   logic          sr_full_ff, sr_full_in;
   logic          arm_ff, arm_in;
   logic [7:0]    ack_seq_ff, ack_seq_in;
   logic [7:0]    nss_ff, nss_in;
   logic [8:0]    exp_ff, exp_in;
   logic [6:0]    mult_ff, mult_in;
   logic [3:0]    max_ret_ff, max_ret_in;
   logic [15:0]   buf_tag_ff [TX_LIMIT_N];
   logic [7:0]    buf_seq_ff [TX_LIMIT_N];

   logic               buf_we;
   logic [2:0]         buf_idx;
   logic               q_shift;
   logic               q_load;
   logic [IW-1:0]      q_idx;
   swr_pkg::entry_type q_data;
   swr_pkg::entry_type head;
   swr_pkg::entry_type cell_q [QUEUE_DEPTH];

   logic       req_fire;
   logic       rsp_fire;
   logic       csr_wr;
   logic [3:0] ret_left;
   logic [7:0] win_hi;
   logic       win_hit;
   logic       rsp_last;

   assign head     = cell_q[0];
   assign req_fire = req_ch.valid & req_ch.ready;
   assign rsp_fire = rsp_ch.valid & rsp_ch.ready;
   assign csr_wr   = csr_psel & csr_penable & csr_pwrite & csr_pready
                     & (csr_paddr[2] == swr_pkg::REG_MAX_RETRIES);

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == swr_pkg::REG_MAX_RETRIES) ? {28'd0, max_ret_ff} : 32'd0;

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         swr_pkg::cell_ctl_type ctl;
         swr_pkg::entry_type    right;
         assign ctl.shift = q_shift;
         assign ctl.load  = q_load && (q_idx == IW'(gi));
         assign ctl.data  = q_data;
         if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign right = cell_q[gi];
         end else begin : g_mid
            assign right = cell_q[gi + 1];
         end
         swr_cell u_cell (
            .clock (clock),
            .ctl   (ctl),
            .right (right),
            .q     (cell_q[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      writes_in  = writes_ff;
      k_in       = k_ff;
      nres_in    = nres_ff;
      use_buf_in = use_buf_ff;
      sr_kind_in = sr_kind_ff;
      sr_tag_in  = sr_tag_ff;
      sr_seq_in  = sr_seq_ff;
      sr_acc_in  = sr_acc_ff;
      sr_full_in = sr_full_ff;
      arm_in     = arm_ff;
      ack_seq_in = ack_seq_ff;
      nss_in     = nss_ff;
      exp_in     = exp_ff;
      mult_in    = mult_ff;
      max_ret_in = csr_wr ? csr_pwdata[3:0] : max_ret_ff;
      buf_we     = 1'b0;
      buf_idx    = writes_ff[2:0];
      q_shift    = 1'b0;
      q_load     = 1'b0;
      q_idx      = cnt_ff[IW-1:0];
      q_data     = head;
      ret_left   = head.retries;
      win_hi     = 8'd0;
      win_hit    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               use_buf_in = 1'b0;
               k_in       = 4'd0;
               sr_kind_in = 1'b1;
               sr_tag_in  = 16'd0;
               sr_seq_in  = 8'd0;
               sr_acc_in  = 1'b0;
               sr_full_in = 1'b0;
               arm_in     = 1'b0;
               unique case (req_ch.action)
                  swr_pkg::ACT_SEND: begin
                     state_in = ST_EMIT;
                     if (32'(cnt_ff) >= 32'(QUEUE_DEPTH)) begin
                        sr_full_in = 1'b1;
                     end else begin
                        q_load      = 1'b1;
                        q_data.tag  = req_ch.msg_tag;
                        q_data.seq  = nss_ff;
                        q_data.retries = max_ret_ff;
                        cnt_in      = cnt_ff + CW'(1);
                        nss_in      = 8'((32'(nss_ff) + 32'd1) % swr_pkg::SEQ_MODULO);
                        sr_seq_in   = nss_ff;
                        if (32'(cnt_ff) < 32'(swr_pkg::WINDOW - 1)) begin
                           sr_kind_in = 1'b0;
                           sr_tag_in  = req_ch.msg_tag;
                           arm_in     = 1'b1;
                        end
                     end
                  end
                  swr_pkg::ACT_TICK: begin
                     rem_in    = cnt_ff;
                     writes_in = 4'd0;
                     state_in  = ST_PASS;
                  end
                  swr_pkg::ACT_ACK: begin
                     ack_seq_in = req_ch.seq_in;
                     state_in   = ST_ACK;
                  end
                  default: begin
                     win_hi  = 8'((32'(exp_ff) + 32'(swr_pkg::WINDOW) * 32'(mult_ff))
                                  % swr_pkg::SEQ_MODULO);
                     win_hit = (exp_ff <= {1'b0, req_ch.seq_in})
                               || ((req_ch.seq_in < win_hi) && ({1'b0, win_hi} < exp_ff));
                     if (win_hit) begin
                        mult_in = 7'd1;
                        exp_in  = {1'b0, req_ch.seq_in} + 9'd1;
                     end else if (32'(mult_ff) <= 32'(swr_pkg::MULT_RESET)) begin
                        mult_in = {mult_ff[5:0], 1'b0};
                     end
                     sr_acc_in = win_hit;
                     state_in  = ST_EMIT;
                  end
               endcase
            end
         end
         ST_PASS: begin
            if (rem_ff == '0) begin
               k_in     = 4'd0;
               arm_in   = (cnt_ff != '0);
               state_in = ST_EMIT;
               if (writes_ff == 4'd0) begin
                  use_buf_in = 1'b0;
                  sr_kind_in = 1'b1;
                  sr_tag_in  = 16'd0;
                  sr_seq_in  = 8'd0;
                  sr_acc_in  = 1'b0;
                  sr_full_in = 1'b0;
               end else begin
                  use_buf_in = 1'b1;
                  nres_in    = writes_ff;
               end
            end else begin
               q_shift = 1'b1;
               rem_in  = rem_ff - CW'(1);
               if ((head.retries != 4'd0) && (writes_ff < 4'(TX_LIMIT_N))) begin
                  buf_we    = 1'b1;
                  writes_in = writes_ff + 4'd1;
                  ret_left  = head.retries - 4'd1;
               end
               if (ret_left != 4'd0) begin
                  // entry survives: it goes back in at the tail slot the shift leaves open
                  q_load         = 1'b1;
                  q_idx          = IW'(cnt_ff - CW'(1));
                  q_data.retries = ret_left;
               end else begin
                  cnt_in = cnt_ff - CW'(1);
               end
            end
         end
         ST_ACK: begin
            win_hi  = 8'((32'(head.seq) + 32'(swr_pkg::WINDOW)) % swr_pkg::SEQ_MODULO);
            win_hit = (head.seq <= ack_seq_ff)
                      || ((ack_seq_ff < win_hi) && (win_hi < head.seq));
            if ((cnt_ff != '0) && win_hit) begin
               q_shift = 1'b1;
               cnt_in  = cnt_ff - CW'(1);
            end else if (cnt_ff != '0) begin
               rem_in    = cnt_ff;
               writes_in = 4'd0;
               state_in  = ST_PASS;
            end else begin
               use_buf_in = 1'b0;
               k_in       = 4'd0;
               sr_kind_in = 1'b1;
               sr_tag_in  = 16'd0;
               sr_seq_in  = 8'd0;
               sr_acc_in  = 1'b0;
               sr_full_in = 1'b0;
               arm_in     = 1'b0;
               state_in   = ST_EMIT;
            end
         end
         default: begin
            if (rsp_fire) begin
               if (use_buf_ff && ((k_ff + 4'd1) < nres_ff)) begin
                  k_in = k_ff + 4'd1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         rem_ff     <= '0;
         writes_ff  <= 4'd0;
         k_ff       <= 4'd0;
         nres_ff    <= 4'd0;
         use_buf_ff <= 1'b0;
         arm_ff     <= 1'b0;
         nss_ff     <= 8'd0;
         exp_ff     <= 9'd0;
         mult_ff    <= 7'(swr_pkg::MULT_RESET);
         max_ret_ff <= 4'd3;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rem_ff     <= rem_in;
         writes_ff  <= writes_in;
         k_ff       <= k_in;
         nres_ff    <= nres_in;
         use_buf_ff <= use_buf_in;
         arm_ff     <= arm_in;
         nss_ff     <= nss_in;
         exp_ff     <= exp_in;
         mult_ff    <= mult_in;
         max_ret_ff <= max_ret_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_kind_ff <= sr_kind_in;
      sr_tag_ff  <= sr_tag_in;
      sr_seq_ff  <= sr_seq_in;
      sr_acc_ff  <= sr_acc_in;
      sr_full_ff <= sr_full_in;
      ack_seq_ff <= ack_seq_in;
      if (buf_we) begin
         buf_tag_ff[buf_idx] <= head.tag;
         buf_seq_ff[buf_idx] <= head.seq;
      end
   end

   assign rsp_last = !use_buf_ff || ((k_ff + 4'd1) == nres_ff);

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = (state_ff == ST_EMIT);
   assign rsp_ch.kind        = use_buf_ff ? 1'b0 : sr_kind_ff;
   assign rsp_ch.out_tag     = use_buf_ff ? buf_tag_ff[k_ff[2:0]] : sr_tag_ff;
   assign rsp_ch.out_seq     = use_buf_ff ? buf_seq_ff[k_ff[2:0]] : sr_seq_ff;
   assign rsp_ch.accepted    = use_buf_ff ? 1'b0 : sr_acc_ff;
   assign rsp_ch.queue_full  = use_buf_ff ? 1'b0 : sr_full_ff;
   assign rsp_ch.arm_timer   = rsp_last & arm_ff;
   assign rsp_ch.pending     = 5'(cnt_ff);
   assign rsp_ch.last        = rsp_last;

   `SWR_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, 32'(cnt_ff) <= 32'(QUEUE_DEPTH),
                   "queue count overflow")
   `SWR_ASSERT_NEXT(a_req_busy, clock, reset, req_fire, state_ff != ST_IDLE,
                    "request not taken up")
   `SWR_ASSERT_NOW(a_buf_index, clock, reset, rsp_ch.valid && use_buf_ff,
                   (k_ff < nres_ff) && (nres_ff <= 4'(TX_LIMIT_N)), "result index out of range")

endmodule

/* hw/rtl/swr_cell.sv */
module swr_cell (
   input  logic                  clock,
   input  swr_pkg::cell_ctl_type ctl,
   input  swr_pkg::entry_type    right,
   output swr_pkg::entry_type    q
);

   swr_pkg::entry_type data_ff;

   // a load from control wins over the shift toward the head
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         data_ff <= ctl.data;
      end else if (ctl.shift) begin
         data_ff <= right;
      end
   end

   assign q = data_ff;

endmodule
